@@ rtl/core/lsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// LIN slave frame receiver package
// Shared types, codes, constants and checksum and parity helpers for the receiver.
// ----------------------------------------------------------------------------
package lsfr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SYNC  = 3'd1,
      PH_IDENT = 3'd2,
      PH_DATA  = 3'd3,
      PH_CHECK = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_FRAME_OK     = 3'd0,
      EV_RESPONSE     = 3'd1,
      EV_SYNC_ERR     = 3'd2,
      EV_PARITY_ERR   = 3'd3,
      EV_CHECKSUM_ERR = 3'd4
   } event_type;

   localparam logic [1:0] REG_CMD_ID      = 2'd0;
   localparam logic [1:0] REG_RSP_ID      = 2'd1;
   localparam logic [1:0] REG_RSP_PAYLOAD = 2'd2;
   localparam logic [1:0] REG_ENHANCED    = 2'd3;

   localparam logic [5:0] CMD_ID_RESET = 6'h31;
   localparam logic [5:0] RSP_ID_RESET = 6'h32;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] ID_MASK    = 8'h3F;
   localparam logic [7:0] CKSUM_GOOD = 8'hFF;

   localparam int MAX_BYTES = 8;

   typedef struct packed {
      logic [5:0]  cmd_id;
      logic [5:0]  rsp_id;
      logic [63:0] rsp_payload;
      logic        enhanced;
   } cfg_type;

   typedef struct packed {
      event_type   kind;
      logic [5:0]  frame_ident;
      logic [7:0]  protected_ident;
      logic [63:0] payload;
   } result_type;

   function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? (s[7:0] + 8'd1) : s[7:0];
   endfunction

   function automatic logic [7:0] protect_id(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

endpackage

@@ rtl/core/lin_slave_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// LIN slave frame receiver
// Decodes UART byte events into LIN frame results with checksum checking.
// ----------------------------------------------------------------------------
// Each request is one UART event; it is held in the input register, where the
// frame decoder acts on it, then the result (if any) is registered in the
// result register. A new request can be accepted every cycle; only a stalled
// result register holds the input back. Configuration writes are always ready
// and should be made only while no request is in flight.
module lin_slave_frame_receiver #(
   parameter int DATA_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_break_seen,
   input  logic        req_framing_error,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [5:0]  rsp_frame_ident,
   output logic [7:0]  rsp_protected_ident,
   output logic [63:0] rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   lsfr_pkg::cfg_type    cfg;
   lsfr_pkg::result_type res;
   lsfr_pkg::result_type rsp_item;
   logic                 res_valid;
   logic                 out_free;
   logic                 fire;
   logic                 accept;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           byte_ff;
   logic                 break_ff;
   logic                 ferr_ff;

   assign fire        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= req_rx_byte;
         break_ff <= req_break_seen;
         ferr_ff  <= req_framing_error;
      end
   end

   lsfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   lsfr_frame #(
      .DATA_BYTES (DATA_BYTES)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .rx_byte       (byte_ff),
      .break_seen    (break_ff),
      .framing_error (ferr_ff),
      .cfg           (cfg),
      .res_valid     (res_valid),
      .res           (res)
   );

   lsfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_event_kind      = rsp_item.kind;
   assign rsp_frame_ident     = rsp_item.frame_ident;
   assign rsp_protected_ident = rsp_item.protected_ident;
   assign rsp_payload         = rsp_item.payload;

endmodule

@@ rtl/core/lsfr_csr.sv @@
// ----------------------------------------------------------------------------
// LIN receiver configuration registers
// Holds the command and response identifiers, response bytes and checksum mode.
// ----------------------------------------------------------------------------
module lsfr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata,
   output logic              csr_ready,
   output lsfr_pkg::cfg_type cfg
);

   lsfr_pkg::cfg_type cfg_ff;
   lsfr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lsfr_pkg::REG_CMD_ID:      cfg_in.cmd_id      = csr_wdata[5:0];
            lsfr_pkg::REG_RSP_ID:      cfg_in.rsp_id      = csr_wdata[5:0];
            lsfr_pkg::REG_RSP_PAYLOAD: cfg_in.rsp_payload = csr_wdata;
            lsfr_pkg::REG_ENHANCED:    cfg_in.enhanced    = csr_wdata[0];
            default:                   cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cmd_id      <= lsfr_pkg::CMD_ID_RESET;
         cfg_ff.rsp_id      <= lsfr_pkg::RSP_ID_RESET;
         cfg_ff.rsp_payload <= 64'd0;
         cfg_ff.enhanced    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/lsfr_frame.sv @@
// ----------------------------------------------------------------------------
// LIN receiver frame decoder
// Tracks the frame phase, checks parity and checksum, and forms the result.
// ----------------------------------------------------------------------------
module lsfr_frame #(
   parameter int DATA_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           rx_byte,
   input  logic                 break_seen,
   input  logic                 framing_error,
   input  lsfr_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output lsfr_pkg::result_type res
);

   localparam logic [3:0] CountLimit = 4'(DATA_BYTES);

   lsfr_pkg::phase_type phase_ff;
   lsfr_pkg::phase_type phase_in;
   logic [3:0]          count_ff;
   logic [3:0]          count_in;
   logic [7:0]          ident_ff;
   logic [7:0]          ident_in;
   logic [7:0]          sum_ff;
   logic [7:0]          sum_in;
   logic [7:0]          store_ff [lsfr_pkg::MAX_BYTES];
   logic                store_we;
   logic [3:0]          count_inc;
   logic                parity_ok;
   logic [5:0]          rx_id;
   logic [7:0]          partial_sum;
   logic [7:0]          total_sum;
   logic [63:0]         packed_data;
   logic                live;

   assign live      = !break_seen && !framing_error;
   assign rx_id     = rx_byte[5:0];
   assign parity_ok = lsfr_pkg::protect_id(rx_id) == rx_byte;
   assign count_inc = count_ff + 4'd1;

   assign partial_sum = cfg.enhanced ? lsfr_pkg::carry_add(sum_ff, ident_ff) : sum_ff;
   assign total_sum   = lsfr_pkg::carry_add(partial_sum, rx_byte);

   always_comb begin
      packed_data = 64'd0;
      for (int i = 0; i < lsfr_pkg::MAX_BYTES; i++) begin
         packed_data = {packed_data[55:0], (i < DATA_BYTES) ? store_ff[3'(i)] : 8'd0};
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (break_seen) begin
         phase_in = lsfr_pkg::PH_SYNC;
      end else if (!framing_error) begin
         unique case (phase_ff)
            lsfr_pkg::PH_IDLE: begin
               phase_in = (rx_byte == lsfr_pkg::SYNC_BYTE) ? lsfr_pkg::PH_SYNC
                                                           : lsfr_pkg::PH_IDLE;
            end
            lsfr_pkg::PH_SYNC: begin
               phase_in = (rx_byte == lsfr_pkg::SYNC_BYTE) ? lsfr_pkg::PH_IDENT
                                                           : lsfr_pkg::PH_IDLE;
            end
            lsfr_pkg::PH_IDENT: begin
               phase_in = (parity_ok && rx_id == cfg.cmd_id) ? lsfr_pkg::PH_DATA
                                                             : lsfr_pkg::PH_IDLE;
            end
            lsfr_pkg::PH_DATA: begin
               phase_in = (count_inc >= CountLimit) ? lsfr_pkg::PH_CHECK
                                                    : lsfr_pkg::PH_DATA;
            end
            lsfr_pkg::PH_CHECK: phase_in = lsfr_pkg::PH_IDLE;
            default:            phase_in = lsfr_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      ident_in  = ident_ff;
      sum_in    = sum_ff;
      store_we  = 1'b0;
      res_valid = 1'b0;
      res.kind            = lsfr_pkg::EV_SYNC_ERR;
      res.frame_ident     = 6'd0;
      res.protected_ident = 8'd0;
      res.payload         = 64'd0;
      if (live) begin
         unique case (phase_ff)
            lsfr_pkg::PH_SYNC: begin
               res_valid = rx_byte != lsfr_pkg::SYNC_BYTE;
            end
            lsfr_pkg::PH_IDENT: begin
               res.frame_ident     = rx_id;
               res.protected_ident = rx_byte;
               if (!parity_ok) begin
                  res_valid = 1'b1;
                  res.kind  = lsfr_pkg::EV_PARITY_ERR;
               end else if (rx_id == cfg.cmd_id) begin
                  ident_in = rx_byte;
                  count_in = 4'd0;
                  sum_in   = 8'd0;
               end else if (rx_id == cfg.rsp_id) begin
                  res_valid   = 1'b1;
                  res.kind    = lsfr_pkg::EV_RESPONSE;
                  res.payload = cfg.rsp_payload;
               end
            end
            lsfr_pkg::PH_DATA: begin
               store_we = 1'b1;
               count_in = count_inc;
               sum_in   = lsfr_pkg::carry_add(sum_ff, rx_byte);
            end
            lsfr_pkg::PH_CHECK: begin
               res_valid           = 1'b1;
               res.kind            = (total_sum == lsfr_pkg::CKSUM_GOOD)
                                     ? lsfr_pkg::EV_FRAME_OK : lsfr_pkg::EV_CHECKSUM_ERR;
               res.frame_ident     = ident_ff[5:0];
               res.protected_ident = ident_ff;
               res.payload         = packed_data;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lsfr_pkg::PH_IDLE;
         count_ff <= 4'd0;
         ident_ff <= 8'd0;
         sum_ff   <= 8'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ident_ff <= ident_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store_we) begin
         store_ff[count_ff[2:0]] <= rx_byte;
      end
   end

endmodule

@@ rtl/core/lsfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// LIN receiver result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module lsfr_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 res_valid,
   input  lsfr_pkg::result_type res,
   input  logic                 rsp_stall,
   output logic                 out_free,
   output logic                 rsp_valid,
   output lsfr_pkg::result_type rsp_item
);

   logic                 valid_ff;
   logic                 valid_in;
   lsfr_pkg::result_type item_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign valid_in  = out_free ? (fire && res_valid) : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         item_ff <= res;
      end
   end

endmodule
